// ===== src/mocp_pkg.sv =====
// Shared types, character codes and saturating digit helpers for the CSV order parser.
package mocp_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] HEADER_LINES_RESET = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_BID     = 8'h42;

    localparam logic [2:0] FIELD_TIME   = 3'd0;
    localparam logic [2:0] FIELD_ACTION = 3'd1;
    localparam logic [2:0] FIELD_SIDE   = 3'd2;
    localparam logic [2:0] FIELD_PRICE  = 3'd3;
    localparam logic [2:0] FIELD_SIZE   = 3'd4;
    localparam logic [2:0] FIELD_IDENT  = 3'd5;
    localparam logic [2:0] FIELD_PAST   = 3'd6;

    localparam logic [31:0] PRICE_MAG_MAX = 32'h8000_0000;
    localparam logic [31:0] PRICE_POS_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        KIND_DIGIT,
        KIND_COMMA,
        KIND_NEWLINE,
        KIND_MINUS,
        KIND_OTHER,
        // last byte of a stream taken while skipping headers: clears the line only
        KIND_DROP
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [63:0]        event_time;
        logic [7:0]         action_code;
        logic               is_bid;
        logic signed [31:0] order_price;
        logic [31:0]        quantity;
        logic [63:0]        order_ident;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       end_of_input;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // acc*10+d, saturating at all ones (overflow shows in the top bits)
    function automatic logic [63:0] acc10_64(input logic [63:0] acc, input logic [3:0] d);
        logic [67:0] wide;
        wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {64'd0, d};
        if (wide[67:64] != 4'd0)
            return {64{1'b1}};
        return wide[63:0];
    endfunction

    function automatic logic [31:0] acc10_32(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] wide;
        wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, d};
        if (wide[35:32] != 4'd0)
            return {32{1'b1}};
        return wide[31:0];
    endfunction

    // price magnitude saturates at 2^31 so the negative limit is reachable
    function automatic logic [31:0] acc10_price(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] wide;
        wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, d};
        if (wide > {4'd0, PRICE_MAG_MAX})
            return PRICE_MAG_MAX;
        return wide[31:0];
    endfunction

endpackage

// ===== src/mocp_front.sv =====
// Front end: accepts bytes, skips header lines and classifies each byte for the back end.
module mocp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mocp_pkg::in_item_t  in_data,
    input  logic [1:0]          header_lines,
    input  mocp_pkg::q_status_t q_status,
    output logic                push,
    output mocp_pkg::cmd_t      cmd
);

    logic [1:0] headers_seen_reg;
    logic [1:0] headers_seen_next;
    logic       accept;
    logic       skipping;
    logic       is_digit;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign skipping = headers_seen_reg < header_lines;
    // end of stream during header skipping still has to clear any open line
    assign push     = accept && (!skipping || in_data.end_of_input);
    assign is_digit = (in_data.data_byte >= mocp_pkg::CHAR_ZERO)
                   && (in_data.data_byte <= mocp_pkg::CHAR_NINE);

    always_comb
    begin
        cmd.data_byte    = in_data.data_byte;
        cmd.end_of_input = in_data.end_of_input;
        if (skipping)
            cmd.kind = mocp_pkg::KIND_DROP;
        else if (in_data.data_byte == mocp_pkg::CHAR_NEWLINE)
            cmd.kind = mocp_pkg::KIND_NEWLINE;
        else if (in_data.data_byte == mocp_pkg::CHAR_COMMA)
            cmd.kind = mocp_pkg::KIND_COMMA;
        else if (in_data.data_byte == mocp_pkg::CHAR_MINUS)
            cmd.kind = mocp_pkg::KIND_MINUS;
        else if (is_digit)
            cmd.kind = mocp_pkg::KIND_DIGIT;
        else
            cmd.kind = mocp_pkg::KIND_OTHER;
    end

    always_comb
    begin
        headers_seen_next = headers_seen_reg;
        if (accept)
        begin
            if (skipping && in_data.data_byte == mocp_pkg::CHAR_NEWLINE)
                headers_seen_next = headers_seen_reg + 2'd1;
            // last byte of a stream restarts header skipping
            if (in_data.end_of_input)
                headers_seen_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            headers_seen_reg <= 2'd0;
        else
            headers_seen_reg <= headers_seen_next;
    end

endmodule

// ===== src/mocp_queue.sv =====
// Small FIFO of classified bytes between front and back end.
module mocp_queue #(
    parameter int unsigned DEPTH = mocp_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mocp_pkg::cmd_t      push_data,
    input  logic                pop,
    output mocp_pkg::cmd_t      head,
    output mocp_pkg::q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mocp_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/mocp_back.sv =====
// Back end: field accumulators per line and the output record register.
module mocp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  mocp_pkg::cmd_t      cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mocp_pkg::out_item_t out_data
);

    logic [2:0]  field_index_reg,    field_index_next;
    logic        field_started_reg,  field_started_next;
    logic        field_stopped_reg,  field_stopped_next;
    logic        line_has_data_reg,  line_has_data_next;
    logic [63:0] time_acc_reg,       time_acc_next;
    logic [7:0]  action_hold_reg,    action_hold_next;
    logic        bid_hold_reg,       bid_hold_next;
    logic [31:0] price_mag_reg,      price_mag_next;
    logic        price_negative_reg, price_negative_next;
    logic [31:0] size_acc_reg,       size_acc_next;
    logic [63:0] ident_acc_reg,      ident_acc_next;

    logic        out_valid_reg,      out_valid_next;
    logic [63:0] rec_time_reg;
    logic [7:0]  rec_action_reg;
    logic        rec_bid_reg;
    logic [31:0] rec_mag_reg;
    logic        rec_neg_reg;
    logic [31:0] rec_size_reg;
    logic [63:0] rec_ident_reg;

    logic        is_digit;
    logic [3:0]  digit;
    logic        first;
    logic        close;
    logic        emits;
    logic        out_free;
    logic        load_rec;

    assign is_digit = (cmd.kind == mocp_pkg::KIND_DIGIT);
    assign digit    = cmd.data_byte[3:0];
    assign first    = !field_started_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        field_index_next    = field_index_reg;
        field_started_next  = field_started_reg;
        field_stopped_next  = field_stopped_reg;
        line_has_data_next  = line_has_data_reg;
        time_acc_next       = time_acc_reg;
        action_hold_next    = action_hold_reg;
        bid_hold_next       = bid_hold_reg;
        price_mag_next      = price_mag_reg;
        price_negative_next = price_negative_reg;
        size_acc_next       = size_acc_reg;
        ident_acc_next      = ident_acc_reg;

        if (cmd.kind != mocp_pkg::KIND_NEWLINE && cmd.kind != mocp_pkg::KIND_DROP)
        begin
            line_has_data_next = 1'b1;
            if (cmd.kind == mocp_pkg::KIND_COMMA)
            begin
                if (field_index_reg < mocp_pkg::FIELD_PAST)
                    field_index_next = field_index_reg + 3'd1;
                field_started_next = 1'b0;
                field_stopped_next = 1'b0;
            end
            else if (field_index_reg < mocp_pkg::FIELD_PAST)
            begin
                field_started_next = 1'b1;
                if (!field_stopped_reg)
                begin
                    case (field_index_reg)
                        mocp_pkg::FIELD_TIME:
                        begin
                            if (is_digit)
                                time_acc_next = mocp_pkg::acc10_64(time_acc_reg, digit);
                            else
                                field_stopped_next = 1'b1;
                        end
                        mocp_pkg::FIELD_ACTION:
                        begin
                            action_hold_next   = cmd.data_byte;
                            field_stopped_next = 1'b1;
                        end
                        mocp_pkg::FIELD_SIDE:
                        begin
                            bid_hold_next      = (cmd.data_byte == mocp_pkg::CHAR_BID);
                            field_stopped_next = 1'b1;
                        end
                        mocp_pkg::FIELD_PRICE:
                        begin
                            if (first && cmd.kind == mocp_pkg::KIND_MINUS)
                                price_negative_next = 1'b1;
                            else if (is_digit)
                                price_mag_next = mocp_pkg::acc10_price(price_mag_reg, digit);
                            else
                                field_stopped_next = 1'b1;
                        end
                        mocp_pkg::FIELD_SIZE:
                        begin
                            if (is_digit)
                                size_acc_next = mocp_pkg::acc10_32(size_acc_reg, digit);
                            else
                                field_stopped_next = 1'b1;
                        end
                        default:
                        begin
                            if (is_digit)
                                ident_acc_next = mocp_pkg::acc10_64(ident_acc_reg, digit);
                            else
                                field_stopped_next = 1'b1;
                        end
                    endcase
                end
            end
        end

        close    = (cmd.kind == mocp_pkg::KIND_NEWLINE) || cmd.end_of_input;
        emits    = close && line_has_data_next && (cmd.kind != mocp_pkg::KIND_DROP);
        // a record-producing item waits for the output slot; others never wait
        pop      = cmd_valid && (!emits || out_free);
        load_rec = pop && emits;

        if (load_rec)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg    <= mocp_pkg::FIELD_TIME;
            field_started_reg  <= 1'b0;
            field_stopped_reg  <= 1'b0;
            line_has_data_reg  <= 1'b0;
            time_acc_reg       <= '0;
            action_hold_reg    <= '0;
            bid_hold_reg       <= 1'b0;
            price_mag_reg      <= '0;
            price_negative_reg <= 1'b0;
            size_acc_reg       <= '0;
            ident_acc_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (close)
                begin
                    field_index_reg    <= mocp_pkg::FIELD_TIME;
                    field_started_reg  <= 1'b0;
                    field_stopped_reg  <= 1'b0;
                    line_has_data_reg  <= 1'b0;
                    time_acc_reg       <= '0;
                    action_hold_reg    <= '0;
                    bid_hold_reg       <= 1'b0;
                    price_mag_reg      <= '0;
                    price_negative_reg <= 1'b0;
                    size_acc_reg       <= '0;
                    ident_acc_reg      <= '0;
                end
                else
                begin
                    field_index_reg    <= field_index_next;
                    field_started_reg  <= field_started_next;
                    field_stopped_reg  <= field_stopped_next;
                    line_has_data_reg  <= line_has_data_next;
                    time_acc_reg       <= time_acc_next;
                    action_hold_reg    <= action_hold_next;
                    bid_hold_reg       <= bid_hold_next;
                    price_mag_reg      <= price_mag_next;
                    price_negative_reg <= price_negative_next;
                    size_acc_reg       <= size_acc_next;
                    ident_acc_reg      <= ident_acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rec)
        begin
            rec_time_reg   <= time_acc_next;
            rec_action_reg <= action_hold_next;
            rec_bid_reg    <= bid_hold_next;
            rec_mag_reg    <= price_mag_next;
            rec_neg_reg    <= price_negative_next;
            rec_size_reg   <= size_acc_next;
            rec_ident_reg  <= ident_acc_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_data.event_time  = rec_time_reg;
    assign out_data.action_code = rec_action_reg;
    assign out_data.is_bid      = rec_bid_reg;
    assign out_data.quantity    = rec_size_reg;
    assign out_data.order_ident = rec_ident_reg;
    // positive prices clip at 2^31-1; magnitude 2^31 negates to the minimum
    assign out_data.order_price = rec_neg_reg ? $signed(32'd0 - rec_mag_reg)
                                : $signed((rec_mag_reg > mocp_pkg::PRICE_POS_MAX)
                                          ? mocp_pkg::PRICE_POS_MAX : rec_mag_reg);

endmodule

// ===== src/market_order_csv_line_parser.sv =====
// Top level of the CSV market-order line parser.
// Input channel: in_valid / in_stall / in_data carries one text byte per item plus an
//   end_of_input flag; an item is taken at a clock edge with in_valid high, in_stall low.
// Output channel: out_valid / out_stall / out_data carries one parsed record per line.
// Config channel: cfg_valid / cfg_ready / cfg_data writes header_lines (reset value 2);
//   cfg_ready is always high, write only while no bytes are in flight.
// Throughput: one byte per cycle unless stalled (one back-end shift-add per digit).
// A record passes through the queue and the output record register: out_valid rises
//   right after the edge that pops the newline or end_of_input byte from the queue;
//   that pop waits for any bytes ahead of it and for a free output register.
// A line with no bytes gives no record; header lines are dropped in the front end.
// When out_stall holds a record, the back end keeps consuming bytes that close no line;
//   the queue of QUEUE_DEPTH items then fills and in_stall rises until the record leaves.
// Reset (rst_n low, asynchronous) empties the queue and output register, clears
//   all field accumulators and the header count, and restores header_lines to 2.
module market_order_csv_line_parser #(
    parameter int unsigned QUEUE_DEPTH = mocp_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mocp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mocp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);

    logic [1:0]          header_lines_reg;
    logic                push;
    logic                pop;
    mocp_pkg::cmd_t      push_cmd;
    mocp_pkg::cmd_t      head_cmd;
    mocp_pkg::q_status_t q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_lines_reg <= mocp_pkg::HEADER_LINES_RESET;
        else if (cfg_valid && cfg_ready)
            header_lines_reg <= cfg_data;
    end

    mocp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .header_lines (header_lines_reg),
        .q_status     (q_status),
        .push         (push),
        .cmd          (push_cmd)
    );

    mocp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .status    (q_status)
    );

    mocp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_status.empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== src/mocp_checker.sv =====
// Port-level checks for the CSV order parser, bound to the top level.
module mocp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input mocp_pkg::out_item_t out_data
);

    // a stalled record stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("record dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("record changed while stalled");

    // input backpressure only follows a blocked output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a blocked output");

    // once the output drains, the queue frees a slot at the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !out_stall) |=> !in_stall)
        else $error("input stall outlived output backpressure");

endmodule

bind market_order_csv_line_parser mocp_checker u_mocp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
